// ----- design/opfc_pkg.sv -----
// Package for the odd prime factor counter.
// Holds the sequencer state type and the fixed field widths and constants.
// No dependencies.
package opfc_pkg;

    localparam int COUNT_W = 4;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 4'd15;
    localparam logic [COUNT_W-1:0] TARGET_RESET = 4'd3;
    localparam int FIRST_DIVISOR = 3;
    localparam int DIVISOR_STEP  = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_DONE
    } opfc_state_t;

endpackage

// ----- design/opfc_divider.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Shared unit of the odd prime factor counter; standalone, no package needed.
// Divisor must be nonzero.
module opfc_divider #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    always_comb begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[W]) begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- design/odd_prime_factor_counter.sv -----
// Odd prime factor counter: top level with the trial division sequencer.
// Depends on opfc_pkg and opfc_divider.
//
// Each item carries one unsigned VALUE_WIDTH-bit number. An even value (zero
// included) yields is_even with a count of zero and no match. An odd value is
// factored by trial division with odd divisors 3, 5, 7 and so on, through one
// shared bit-serial divider; the divisor runs up to the square root of the
// remaining value, plus one extra division each time a factor divides it.
// s_tready is high only while no item is in work; a finished result waits in
// the output register without blocking the input. target_count (reset 3) is
// written through cfg_we / cfg_wdata; the user must write it only while idle,
// as the block itself does not enforce this.
module odd_prime_factor_counter
    import opfc_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [COUNT_W-1:0]               cfg_wdata,   // target_count
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata,     // [VALUE_WIDTH-1:0] value
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,     // [3:0] odd_factor_count
    output logic [1:0]                       m_tuser      // [0] is_even, [1] matches_target
);

    localparam int W = VALUE_WIDTH;

    opfc_state_t        state_reg, state_next;
    logic [W-1:0]       n_reg, n_next;
    logic [W-1:0]       d_reg, d_next;
    logic               fresh_reg, fresh_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               even_reg, even_next;
    logic [COUNT_W-1:0] target_reg;
    logic               m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic               m_even_reg, m_even_next;
    logic               m_match_reg, m_match_next;
    logic               div_start;
    logic               div_done;
    logic [W-1:0]       div_quo;
    logic [W-1:0]       div_rem;
    logic [W-1:0]       s_value;
    logic [COUNT_W-1:0] count_inc;

    assign s_value   = s_tdata[W-1:0];
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    opfc_divider #(.W(W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        fresh_next   = fresh_reg;
        count_next   = count_reg;
        even_next    = even_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_count_next = m_count_reg;
        m_even_next  = m_even_reg;
        m_match_next = m_match_reg;
        div_start    = 1'b0;
        s_tready     = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_next     = s_value;
                    d_next     = W'(FIRST_DIVISOR);
                    fresh_next = 1'b1;
                    count_next = '0;
                    even_next  = ~s_value[0];
                    state_next = s_value[0] ? ST_START : ST_DONE;
                end
            end
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_done) begin
                    if (fresh_reg && (d_reg > div_quo)) begin
                        if (n_reg > W'(1)) begin
                            count_next = count_inc;
                        end
                        state_next = ST_DONE;
                    end else if (div_rem == '0) begin
                        if (fresh_reg) begin
                            count_next = count_inc;
                        end
                        n_next     = div_quo;
                        fresh_next = 1'b0;
                        state_next = ST_START;
                    end else begin
                        d_next     = d_reg + W'(DIVISOR_STEP);
                        fresh_next = 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_count_next = even_reg ? '0 : count_reg;
                    m_even_next  = even_reg;
                    m_match_next = !even_reg && (count_reg == target_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            target_reg  <= TARGET_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                target_reg <= cfg_wdata;
            end
        end
        n_reg       <= n_next;
        d_reg       <= d_next;
        fresh_reg   <= fresh_next;
        count_reg   <= count_next;
        even_reg    <= even_next;
        m_count_reg <= m_count_next;
        m_even_reg  <= m_even_next;
        m_match_reg <= m_match_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8 - COUNT_W){1'b0}}, m_count_reg};
    assign m_tuser  = {m_match_reg, m_even_reg};

endmodule

// ----- tb/tb_odd_prime_factor_counter.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for odd_prime_factor_counter: streams numbers through the
// block with random gaps and stalls, predicts each count by trial division and compares.
// Depends on opfc_pkg and the odd_prime_factor_counter RTL.
module tb_odd_prime_factor_counter;
    import opfc_pkg::*;

    localparam int VW        = 32;
    localparam int DIV_COST  = VW + 3;
    localparam int MAX_IDLE  = 40;
    localparam int TAIL_WAIT = 50;

    typedef struct packed {
        logic [COUNT_W-1:0] odd_count;
        logic               even;
        logic               hit;
    } factor_result_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [COUNT_W-1:0]               cfg_wdata = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [((VW+7)/8)*8-1:0]          s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [7:0]                       m_tdata;
    logic [1:0]                       m_tuser;

    logic [VW-1:0]      pending_values[$];
    factor_result_t     expected_results[$];
    logic [COUNT_W-1:0] goal_count = TARGET_RESET;
    int unsigned        error_count = 0;
    longint unsigned    cycle_count = 0;
    longint unsigned    cycle_limit = 200000;
    int unsigned        send_gap = 0;
    int unsigned        recv_stall = 0;

    int unsigned small_primes[24] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                      43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

    odd_prime_factor_counter #(
        .VALUE_WIDTH(VW)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, MAX_IDLE);
    endfunction

    function automatic factor_result_t count_odd_factors(input logic [VW-1:0] value,
                                                         input logic [COUNT_W-1:0] goal,
                                                         output int unsigned divisions);
        factor_result_t  res;
        longint unsigned rem;
        longint unsigned divisor;
        int unsigned     found;
        res = '0;
        divisions = 0;
        if (!value[0]) begin
            res.even = 1'b1;
            return res;
        end
        rem = value;
        divisor = FIRST_DIVISOR;
        found = 0;
        while (divisor * divisor <= rem) begin
            if (rem % divisor == 0) begin
                if (found < COUNT_MAX) found++;
                while (rem % divisor == 0) begin
                    rem = rem / divisor;
                    divisions++;
                end
            end
            divisions++;
            divisor += DIVISOR_STEP;
        end
        if (rem > 1 && found < COUNT_MAX) found++;
        res.odd_count = found[COUNT_W-1:0];
        res.hit = (res.odd_count == goal);
        return res;
    endfunction

    // odd number built from distinct small primes, some raised to powers,
    // optionally with one medium leftover factor
    function automatic logic [VW-1:0] smooth_odd(input int unsigned want);
        longint unsigned prod;
        longint unsigned p;
        logic [23:0]     used;
        int unsigned     idx;
        int unsigned     taken;
        prod = 1;
        used = '0;
        taken = 0;
        repeat (want) begin
            idx = $urandom_range(0, 23);
            while (used[idx]) idx = (idx + 1) % 24;
            used[idx] = 1'b1;
            p = small_primes[idx];
            if (prod * p < (64'd1 << VW)) begin
                prod = prod * p;
                taken++;
                while ($urandom_range(0, 2) == 0 && prod * p < (64'd1 << VW)) prod = prod * p;
            end
        end
        if (taken == want && $urandom_range(0, 3) == 0) begin
            p = $urandom_range(101, 65535) | 1;
            if (prod * p < (64'd1 << VW)) prod = prod * p;
        end
        return prod[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] random_value(input logic [COUNT_W-1:0] goal);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            return VW'({$urandom(), 1'b0});
        end else if (r < 45) begin
            return $urandom_range(1, 4095) | 1;
        end else if (r < 65) begin
            return smooth_odd((goal <= 9) ? goal : 9);
        end else if (r < 90) begin
            return smooth_odd($urandom_range(1, 9));
        end
        return $urandom_range(1, 1 << 20) | 1;
    endfunction

    always @(posedge aclk) begin
        int unsigned    divisions;
        factor_result_t res;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                res = count_odd_factors(s_tdata[VW-1:0], goal_count, divisions);
                expected_results = {expected_results, res};
                cycle_limit += 4 * ((divisions + 4) * DIV_COST + 4 * MAX_IDLE);
            end
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_values.size() > 0) begin
                    s_tdata <= pending_values.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap = pick_idle();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        factor_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected item: count %0d even %0b match %0b",
                                 m_tdata[3:0], m_tuser[0], m_tuser[1]);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[3:0] !== want.odd_count || m_tuser[0] !== want.even ||
                        m_tuser[1] !== want.hit) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: expected %0d %0b %0b got %0d %0b %0b",
                                     want.odd_count, want.even, want.hit,
                                     m_tdata[3:0], m_tuser[0], m_tuser[1]);
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_stall = pick_idle();
            end
        end
    end

    task automatic wait_drained();
        while (pending_values.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_goal(input logic [COUNT_W-1:0] goal);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= goal;
        @(posedge aclk);
        cfg_we <= 1'b0;
        goal_count = goal;
    endtask

    initial begin
        while (cycle_count < cycle_limit) @(posedge aclk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [COUNT_W-1:0] phase_goals[7];
        phase_goals = '{4'd0, 4'd15, 4'd1, 4'd4, 4'd2, 4'd5, 4'd0};
        phase_goals[5] = COUNT_W'($urandom_range(0, 15));
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        pending_values = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd9, 32'd25, 32'd35, 32'd45,
                           32'd15, 32'd105, 32'd1155, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                           32'h8000_0000, 32'h5555_5555, 32'd3486784401, 32'd111546435,
                           32'd3234846615, 32'd65521, 32'd16777213, 32'd49};
        wait_drained();

        foreach (phase_goals[i]) begin
            write_goal(phase_goals[i]);
            if (phase_goals[i] == 0) pending_values = {pending_values, VW'(1)};
            repeat (11) pending_values = {pending_values, random_value(phase_goals[i])};
            wait_drained();
        end

        repeat (TAIL_WAIT) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
